FILE: hdl/lpac_pkg.sv
// lpac_pkg: shared types, codes and constants of the link pairing ack controller
// no dependencies; imported by link_pairing_ack_controller_unit

package lpac_pkg;

	// link phase, one-hot
	typedef enum logic [3:0] {
		PH_INIT    = 4'b0001,
		PH_PENDING = 4'b0010,
		PH_PAIRED  = 4'b0100,
		PH_SENDING = 4'b1000
	} phase_t;

	// phase codes as reported on link_state
	localparam logic [1:0] LS_INIT    = 2'd0;
	localparam logic [1:0] LS_PENDING = 2'd1;
	localparam logic [1:0] LS_PAIRED  = 2'd2;
	localparam logic [1:0] LS_SENDING = 2'd3;

	// item kinds on mode
	localparam logic [1:0] MODE_TICK     = 2'd0;
	localparam logic [1:0] MODE_PAIR_ACK = 2'd1;
	localparam logic [1:0] MODE_DATA_ACK = 2'd2;

	// transmit kinds on tx_kind
	localparam logic [1:0] TX_NONE = 2'd0;
	localparam logic [1:0] TX_PAIR = 2'd1;
	localparam logic [1:0] TX_DATA = 2'd2;

	// register indexes
	localparam logic [1:0] REG_RSSI_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_DEBOUNCE       = 2'd1;
	localparam logic [1:0] REG_ACK_TIMEOUT    = 2'd2;
	localparam logic [1:0] REG_LINK_TIMEOUT   = 2'd3;

	// register reset values
	localparam logic signed [7:0] RSSI_THRESHOLD_RST = -8'sd60;
	localparam logic [7:0]        DEBOUNCE_RST       = 8'd5;
	localparam logic [15:0]       ACK_TIMEOUT_RST    = 16'd10;
	localparam logic [15:0]       LINK_TIMEOUT_RST   = 16'd500;

	localparam logic [19:0] MSG_WRAP  = 20'd1000000;
	localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  mode;
		logic        button_level;
		logic [7:0]  rx_rssi;
		logic        frame_is_pair_ack;
		logic [31:0] frame_code;
		logic [31:0] frame_device_id;
		logic [47:0] frame_mac;
		logic [47:0] source_mac;
		logic        prev_send_failed;
	} item_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		unique case (ph)
			PH_INIT:    code = LS_INIT;
			PH_PENDING: code = LS_PENDING;
			PH_PAIRED:  code = LS_PAIRED;
			PH_SENDING: code = LS_SENDING;
			default:    code = LS_INIT;
		endcase
		return code;
	endfunction

endpackage

FILE: hdl/link_pairing_ack_controller_unit.sv
// link_pairing_ack_controller_unit: top level of the pair-then-stream link master
// depends on lpac_pkg (types, codes, constants)

// one item is taken per clock cycle while the result is not stalled: an input
// register holds the accepted item, compare and update logic against the link
// state registers produces the next state and the result, and a result register
// presents it. the state feedback closes within that logic, so consecutive items
// follow back to back. a stalled result holds the result register; the input
// register, if empty, still takes one more item, after which item_stall rises.
// config registers are written through cfg_valid/cfg_ready, always ready, and
// should only be written while no item is in flight
module link_pairing_ack_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  mode,
	input  logic        button_level,
	input  logic signed [7:0] rx_rssi,
	input  logic        frame_is_pair_ack,
	input  logic [31:0] frame_code,
	input  logic [31:0] frame_device_id,
	input  logic [47:0] frame_mac,
	input  logic [47:0] source_mac,
	input  logic        prev_send_failed,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  tx_kind,
	output logic [19:0] tx_msg_num,
	output logic [31:0] tx_pairing_code,
	output logic [47:0] dest_mac,
	output logic        led_on,
	output logic [1:0]  link_state,
	output logic [31:0] sent_count,
	output logic [31:0] partner_id,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import lpac_pkg::*;

	// config registers
	logic signed [7:0] rssi_thr_q;
	logic [7:0]        debounce_q;
	logic [15:0]       ack_to_q;
	logic [15:0]       link_to_q;

	// link state
	phase_t      phase_q;
	logic        paired_q;
	logic [31:0] code_q;
	logic [47:0] pmac_q;
	logic [31:0] ident_q;
	logic [19:0] msg_q;
	logic        ack_seen_q;
	logic [31:0] tick_q;
	logic [31:0] last_send_q;
	logic [31:0] last_ack_q;
	logic [31:0] last_press_q;
	logic        prev_btn_q;
	logic signed [7:0] rssi_q;
	logic [31:0] frames_q;

	// input stage
	logic  valid_s1;
	item_t item_s1;

	// result register
	logic        res_valid_q;
	logic [1:0]  tx_kind_q;
	logic [19:0] tx_msg_q;
	logic [31:0] tx_code_q;
	logic [47:0] dest_mac_q;
	logic        led_q;
	logic [1:0]  link_state_q;
	logic [31:0] sent_q;
	logic [31:0] partner_q;

	// handshake
	logic advance;
	logic item_take;

	// next state
	phase_t      phase_n;
	logic        paired_n;
	logic [31:0] code_n;
	logic [47:0] pmac_n;
	logic [31:0] ident_n;
	logic [19:0] msg_n;
	logic        ack_n;
	logic [31:0] tick_n;
	logic [31:0] last_send_n;
	logic [31:0] last_ack_n;
	logic [31:0] last_press_n;
	logic        prev_btn_n;
	logic signed [7:0] rssi_n;
	logic [31:0] frames_n;
	logic [1:0]  tx_n;
	logic [19:0] msg_wrapped;

	// result slot frees when empty or being taken this edge
	assign advance   = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign item_take = item_valid && !item_stall;
	assign cfg_ready = 1'b1;

	// counter never passes the wrap value, so one compare and subtract suffices
	assign msg_wrapped = ((msg_q >= MSG_WRAP) ? (msg_q - MSG_WRAP) : msg_q) + 20'd1;

	always_comb begin
		phase_n      = phase_q;
		paired_n     = paired_q;
		code_n       = code_q;
		pmac_n       = pmac_q;
		ident_n      = ident_q;
		msg_n        = msg_q;
		ack_n        = ack_seen_q;
		tick_n       = tick_q;
		last_send_n  = last_send_q;
		last_ack_n   = last_ack_q;
		last_press_n = last_press_q;
		prev_btn_n   = prev_btn_q;
		rssi_n       = rssi_q;
		frames_n     = frames_q;
		tx_n         = TX_NONE;

		case (item_s1.mode)
			MODE_TICK: begin
				tick_n = tick_q + 32'd1;
				// rejected send: take the outstanding frame back
				if (item_s1.prev_send_failed && phase_q == PH_SENDING && !ack_seen_q) begin
					ack_n    = 1'b1;
					frames_n = frames_q - 32'd1;
				end
				unique case (phase_q)
					PH_INIT: begin
						paired_n    = 1'b0;
						pmac_n      = '0;
						code_n      = '0;
						msg_n       = '0;
						ident_n     = '0;
						ack_n       = 1'b1;
						last_send_n = '0;
						last_ack_n  = '0;
						frames_n    = '0;
						phase_n     = PH_PENDING;
					end
					PH_PENDING: begin
						// debounced rising edge issues a broadcast pair request
						if (item_s1.button_level && !prev_btn_q &&
						    (tick_n - last_press_q) > {24'd0, debounce_q}) begin
							last_press_n = tick_n;
							tx_n         = TX_PAIR;
						end
						prev_btn_n = item_s1.button_level;
					end
					PH_PAIRED: begin
						msg_n      = 20'd1;
						ack_n      = 1'b1;
						last_ack_n = tick_n;
						phase_n    = PH_SENDING;
					end
					PH_SENDING: begin
						if (!paired_q || rssi_q < rssi_thr_q ||
						    (tick_n - last_ack_q) >= {16'd0, link_to_q}) begin
							// weak signal, link timeout or lost pairing
							paired_n = 1'b0;
							ack_n    = 1'b1;
							phase_n  = PH_INIT;
						end else begin
							if (!ack_n && (tick_n - last_send_q) > {16'd0, ack_to_q}) begin
								ack_n = 1'b1;
							end
							if (ack_n) begin
								ack_n       = 1'b0;
								last_send_n = tick_n;
								frames_n    = frames_n + 32'd1;
								tx_n        = TX_DATA;
							end
						end
					end
					default: begin
						phase_n = PH_INIT;
					end
				endcase
			end
			MODE_PAIR_ACK: begin
				rssi_n = item_s1.rx_rssi;
				if (item_s1.frame_is_pair_ack && !paired_q &&
				    $signed(item_s1.rx_rssi) >= rssi_thr_q) begin
					code_n   = item_s1.frame_code;
					ident_n  = item_s1.frame_device_id;
					pmac_n   = item_s1.frame_mac;
					paired_n = 1'b1;
					phase_n  = PH_PAIRED;
				end
			end
			MODE_DATA_ACK: begin
				rssi_n = item_s1.rx_rssi;
				if (!paired_q || item_s1.frame_code != code_q ||
				    item_s1.source_mac != pmac_q) begin
					// bad acknowledge drops the pairing
					paired_n = 1'b0;
					pmac_n   = '0;
					code_n   = '0;
					msg_n    = '0;
					ident_n  = '0;
					ack_n    = 1'b1;
					phase_n  = PH_INIT;
				end else begin
					ack_n      = 1'b1;
					msg_n      = msg_wrapped;
					last_ack_n = tick_q;
				end
			end
			default: begin
				// unused mode, state untouched
			end
		endcase
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1.mode              <= mode;
			item_s1.button_level      <= button_level;
			item_s1.rx_rssi           <= rx_rssi;
			item_s1.frame_is_pair_ack <= frame_is_pair_ack;
			item_s1.frame_code        <= frame_code;
			item_s1.frame_device_id   <= frame_device_id;
			item_s1.frame_mac         <= frame_mac;
			item_s1.source_mac        <= source_mac;
			item_s1.prev_send_failed  <= prev_send_failed;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rssi_thr_q <= RSSI_THRESHOLD_RST;
			debounce_q <= DEBOUNCE_RST;
			ack_to_q   <= ACK_TIMEOUT_RST;
			link_to_q  <= LINK_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RSSI_THRESHOLD: rssi_thr_q <= cfg_data[7:0];
				REG_DEBOUNCE:       debounce_q <= cfg_data[7:0];
				REG_ACK_TIMEOUT:    ack_to_q   <= cfg_data;
				REG_LINK_TIMEOUT:   link_to_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// link state, updated as each item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_INIT;
			paired_q     <= 1'b0;
			code_q       <= '0;
			pmac_q       <= '0;
			ident_q      <= '0;
			msg_q        <= '0;
			ack_seen_q   <= 1'b1;
			tick_q       <= '0;
			last_send_q  <= '0;
			last_ack_q   <= '0;
			last_press_q <= '0;
			prev_btn_q   <= 1'b0;
			rssi_q       <= '0;
			frames_q     <= '0;
		end else if (advance) begin
			phase_q      <= phase_n;
			paired_q     <= paired_n;
			code_q       <= code_n;
			pmac_q       <= pmac_n;
			ident_q      <= ident_n;
			msg_q        <= msg_n;
			ack_seen_q   <= ack_n;
			tick_q       <= tick_n;
			last_send_q  <= last_send_n;
			last_ack_q   <= last_ack_n;
			last_press_q <= last_press_n;
			prev_btn_q   <= prev_btn_n;
			rssi_q       <= rssi_n;
			frames_q     <= frames_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tx_kind_q    <= tx_n;
			tx_msg_q     <= (tx_n == TX_DATA) ? msg_n : '0;
			tx_code_q    <= (tx_n == TX_DATA) ? code_n : '0;
			dest_mac_q   <= (tx_n == TX_PAIR) ? MAC_BCAST :
			                ((tx_n == TX_DATA) ? pmac_n : '0);
			led_q        <= paired_n;
			link_state_q <= phase_code(phase_n);
			sent_q       <= frames_n;
			partner_q    <= ident_n;
		end
	end

	assign result_valid    = res_valid_q;
	assign tx_kind         = tx_kind_q;
	assign tx_msg_num      = tx_msg_q;
	assign tx_pairing_code = tx_code_q;
	assign dest_mac        = dest_mac_q;
	assign led_on          = led_q;
	assign link_state      = link_state_q;
	assign sent_count      = sent_q;
	assign partner_id      = partner_q;

endmodule
